>>> sv/vhst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Versioned handle slot table package
// Shared sizes, codes, slot word layout and memory request types.
// ----------------------------------------------------------------------------
package vhst_pkg;

  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned IDX_BITS     = $clog2(SLOTS);
  localparam int unsigned COUNT_BITS   = IDX_BITS + 1;
  localparam int unsigned VERSION_BITS = 16;
  localparam int unsigned OBJECT_BITS  = 32;
  localparam int unsigned ROOT_BITS    = 16;
  localparam int unsigned FUNC_BITS    = 3;
  localparam int unsigned STATUS_BITS  = 3;

  typedef logic [IDX_BITS-1:0]     idx_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [VERSION_BITS-1:0] version_t;
  typedef logic [OBJECT_BITS-1:0]  object_t;
  typedef logic [ROOT_BITS-1:0]    roots_t;

  // Operation codes carried by an input item.
  typedef enum logic [FUNC_BITS-1:0] {
    FN_REGISTER    = 3'd0,
    FN_FREE        = 3'd1,
    FN_PENDING     = 3'd2,
    FN_RESOLVE     = 3'd3,
    FN_ADD_ROOT    = 3'd4,
    FN_REMOVE_ROOT = 3'd5
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    STS_OK        = 3'd0,
    STS_NULL      = 3'd1,
    STS_STALE     = 3'd2,
    STS_BAD_STATE = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

  // Lifecycle state of one slot.
  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_LIVE    = 2'd1,
    SLOT_PENDING = 2'd2
  } slot_state_e;

  // Controller sequencing states.
  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_STACK = 2'd1,
    FSM_EXEC  = 2'd2
  } fsm_e;

  // One word of the slot memory.
  typedef struct packed {
    slot_state_e state;
    version_t    version;
    roots_t      roots;
    object_t     obj;
  } slot_word_t;

  // Request to the slot memory.
  typedef struct packed {
    logic       rd;
    logic       wr;
    idx_t       addr;
    slot_word_t wdata;
  } slot_req_t;

  // Request to the free stack memory.
  typedef struct packed {
    logic rd;
    logic wr;
    idx_t addr;
    idx_t wdata;
  } stack_req_t;

endpackage

>>> sv/vhst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one operation item with its handle and object reference.
// ----------------------------------------------------------------------------
interface vhst_req_if;
  import vhst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FUNC_BITS-1:0]   func;
  logic                   handle_set;
  logic [IDX_BITS-1:0]    slot_index;
  logic [VERSION_BITS-1:0] slot_version;
  logic [OBJECT_BITS-1:0] object_ref;

  modport source (
    output valid, func, handle_set, slot_index, slot_version, object_ref,
    input  ready
  );

  modport sink (
    input  valid, func, handle_set, slot_index, slot_version, object_ref,
    output ready
  );

endinterface

>>> sv/vhst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one result item: status, issued handle, object and live count.
// ----------------------------------------------------------------------------
interface vhst_rsp_if;
  import vhst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [IDX_BITS-1:0]     out_index;
  logic [VERSION_BITS-1:0] out_version;
  logic [OBJECT_BITS-1:0]  out_object;
  logic [COUNT_BITS-1:0]   live_count;

  modport source (
    output valid, status, out_index, out_version, out_object, live_count,
    input  ready
  );

  modport sink (
    input  valid, status, out_index, out_version, out_object, live_count,
    output ready
  );

endinterface

>>> sv/vhst_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot memory
// Single-port synchronous memory holding state, version, roots and object.
// ----------------------------------------------------------------------------
module vhst_slot_mem (
  input  logic                 clk_i,
  input  vhst_pkg::slot_req_t  req_i,
  output vhst_pkg::slot_word_t rdata_o
);
  import vhst_pkg::*;

  slot_word_t mem_q [SLOTS];
  slot_word_t rdata_q;

  // Write and registered read share the one address port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/vhst_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free stack memory
// Single-port synchronous memory holding the indices of freed slots.
// ----------------------------------------------------------------------------
module vhst_stack_mem (
  input  logic                 clk_i,
  input  vhst_pkg::stack_req_t req_i,
  output vhst_pkg::idx_t       rdata_o
);
  import vhst_pkg::*;

  idx_t mem_q [SLOTS];
  idx_t rdata_q;

  // Push writes and pop reads never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/vhst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table controller
// Sequences the memory reads, performs the slot update and holds the result.
// ----------------------------------------------------------------------------
module vhst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vhst_req_if.sink             req_i,
  vhst_rsp_if.source           rsp_o,
  output vhst_pkg::slot_req_t  slot_req_o,
  input  vhst_pkg::slot_word_t slot_rdata_i,
  output vhst_pkg::stack_req_t stack_req_o,
  input  vhst_pkg::idx_t       stack_rdata_i
);
  import vhst_pkg::*;

  fsm_e state_q, state_d;

  // Captured item.
  func_e    func_q;
  logic     set_q;
  idx_t     idx_q;
  version_t ver_q;
  object_t  obj_q;

  // Table bookkeeping.
  count_t free_top_q, free_top_d;
  count_t high_q, high_d;
  count_t live_q, live_d;

  // Result register.
  logic     out_valid_q;
  status_e  out_status_q;
  idx_t     out_index_q;
  version_t out_version_q;
  object_t  out_object_q;
  count_t   out_live_q;

  logic   accept;
  logic   is_reg_in;
  logic   pop_read;
  logic   exec_go;
  count_t top_minus_one;

  // Execution results.
  status_e    ex_status;
  idx_t       ex_index;
  version_t   ex_version;
  object_t    ex_object;
  logic       ex_slot_wr;
  slot_word_t ex_wdata;
  logic       ex_push;
  logic       ex_pop;
  logic       ex_high_inc;
  logic       ex_live_inc;
  logic       ex_live_dec;
  logic       hit;

  assign accept        = req_i.valid && req_i.ready;
  assign is_reg_in     = (func_e'(req_i.func) == FN_REGISTER);
  assign top_minus_one = free_top_q - count_t'(1);
  assign pop_read      = is_reg_in && (free_top_q != '0) && (req_i.object_ref != '0);
  assign exec_go       = (state_q == FSM_EXEC) && (!out_valid_q || rsp_o.ready);

  // Sequencer: next state, ready and memory requests.
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    slot_req_o  = '0;
    stack_req_o = '0;
    unique case (state_q)
      FSM_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          slot_req_o.rd   = !is_reg_in;
          slot_req_o.addr = req_i.slot_index;
          stack_req_o.rd   = pop_read;
          stack_req_o.addr = top_minus_one[IDX_BITS-1:0];
          state_d = pop_read ? FSM_STACK : FSM_EXEC;
        end
      end
      FSM_STACK: begin
        slot_req_o.rd   = 1'b1;
        slot_req_o.addr = stack_rdata_i;
        state_d         = FSM_EXEC;
      end
      FSM_EXEC: begin
        slot_req_o.wr    = exec_go && ex_slot_wr;
        slot_req_o.addr  = idx_q;
        slot_req_o.wdata = ex_wdata;
        stack_req_o.wr    = exec_go && ex_push;
        stack_req_o.addr  = free_top_q[IDX_BITS-1:0];
        stack_req_o.wdata = idx_q;
        if (exec_go) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the item; a popped index replaces the slot index.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(req_i.func);
      set_q  <= req_i.handle_set;
      ver_q  <= req_i.slot_version;
      obj_q  <= req_i.object_ref;
      idx_q  <= is_reg_in ? high_q[IDX_BITS-1:0] : req_i.slot_index;
    end else if (state_q == FSM_STACK) begin
      idx_q <= stack_rdata_i;
    end
  end

  // Handle lookup: set, below the high mark and of matching version.
  assign hit = set_q && ({1'b0, idx_q} < high_q) && (slot_rdata_i.version == ver_q);

  // Read-modify-write of the slot word.
  always_comb begin
    ex_status   = STS_OK;
    ex_index    = '0;
    ex_version  = '0;
    ex_object   = '0;
    ex_slot_wr  = 1'b0;
    ex_wdata    = slot_rdata_i;
    ex_push     = 1'b0;
    ex_pop      = 1'b0;
    ex_high_inc = 1'b0;
    ex_live_inc = 1'b0;
    ex_live_dec = 1'b0;
    if (func_q == FN_REGISTER) begin
      ex_wdata.state = SLOT_LIVE;
      ex_wdata.roots = '0;
      ex_wdata.obj   = obj_q;
      priority if (obj_q == '0) begin
        ex_status = STS_NULL;
      end else if (free_top_q != '0) begin
        ex_pop      = 1'b1;
        ex_slot_wr  = 1'b1;
        ex_live_inc = 1'b1;
        ex_index    = idx_q;
        ex_version  = slot_rdata_i.version;
      end else if (high_q != count_t'(SLOTS)) begin
        // A never-used slot is written with version zero.
        ex_wdata.version = '0;
        ex_high_inc = 1'b1;
        ex_slot_wr  = 1'b1;
        ex_live_inc = 1'b1;
        ex_index    = idx_q;
      end else begin
        ex_status = STS_FULL;
      end
    end else if (!hit) begin
      ex_status = (func_q == FN_FREE || func_q == FN_PENDING || func_q == FN_RESOLVE ||
                   func_q == FN_ADD_ROOT || func_q == FN_REMOVE_ROOT) ?
                  STS_STALE : STS_BAD_STATE;
    end else begin
      unique case (func_q)
        FN_FREE: begin
          if (slot_rdata_i.state == SLOT_LIVE || slot_rdata_i.state == SLOT_PENDING) begin
            ex_live_dec      = (slot_rdata_i.state == SLOT_LIVE);
            ex_slot_wr       = 1'b1;
            ex_wdata.state   = SLOT_FREE;
            ex_wdata.roots   = '0;
            ex_wdata.obj     = '0;
            ex_wdata.version = slot_rdata_i.version + version_t'(1);
            ex_push          = (free_top_q != count_t'(SLOTS));
          end else begin
            ex_status = STS_BAD_STATE;
          end
        end
        FN_PENDING, FN_RESOLVE, FN_ADD_ROOT, FN_REMOVE_ROOT: begin
          if (slot_rdata_i.state != SLOT_LIVE) begin
            ex_status = STS_BAD_STATE;
          end else begin
            unique case (func_q)
              FN_PENDING: begin
                ex_slot_wr     = 1'b1;
                ex_wdata.state = SLOT_PENDING;
                ex_wdata.roots = '0;
                ex_live_dec    = 1'b1;
              end
              FN_RESOLVE: begin
                ex_object = slot_rdata_i.obj;
              end
              FN_ADD_ROOT: begin
                ex_slot_wr = (slot_rdata_i.roots != '1);
                ex_wdata.roots = slot_rdata_i.roots + roots_t'(1);
              end
              default: begin
                ex_slot_wr = (slot_rdata_i.roots != '0);
                ex_wdata.roots = slot_rdata_i.roots - roots_t'(1);
              end
            endcase
          end
        end
        default: begin
          ex_status = STS_BAD_STATE;
        end
      endcase
    end
  end

  // Next values of the table counters.
  always_comb begin
    free_top_d = free_top_q;
    high_d     = high_q;
    live_d     = live_q;
    if (ex_push) begin
      free_top_d = free_top_q + count_t'(1);
    end else if (ex_pop) begin
      free_top_d = top_minus_one;
    end
    if (ex_high_inc) begin
      high_d = high_q + count_t'(1);
    end
    if (ex_live_inc) begin
      live_d = live_q + count_t'(1);
    end else if (ex_live_dec && live_q != '0) begin
      live_d = live_q - count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q  <= '0;
      high_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_go) begin
        free_top_q <= free_top_d;
        high_q     <= high_d;
        live_q     <= live_d;
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_status_q  <= ex_status;
      out_index_q   <= ex_index;
      out_version_q <= ex_version;
      out_object_q  <= ex_object;
      out_live_q    <= live_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_index   = out_index_q;
  assign rsp_o.out_version = out_version_q;
  assign rsp_o.out_object  = out_object_q;
  assign rsp_o.live_count  = out_live_q;

`ifndef SYNTHESIS
  // Every live slot lies below the high mark.
  a_live_le_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= high_q)
    else $error("live count exceeds used slots");

  // The free stack only holds slots that were used.
  a_top_le_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= high_q)
    else $error("free stack deeper than used slots");

  // The slot memory port never reads and writes in one cycle.
  a_slot_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(slot_req_o.rd && slot_req_o.wr))
    else $error("slot memory read and write collide");

  // A new result only comes out of the execute step.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q) == FSM_EXEC)
    else $error("result loaded outside execute step");
`endif

endmodule

>>> sv/versioned_handle_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Versioned handle slot table
// Hands out (index, version) handles and checks them on every later use.
//
// Usage: one request item on req_i (valid/ready) gives exactly one result
// item on rsp_o (valid/ready). Register, free, pending kill, resolve, add
// root and remove root are processed one at a time, in order.
// Each item reads the slot memory, then writes it back; a register that reuses
// a freed slot also reads the free stack memory first, because that must be
// read before the slot memory can be addressed. An item is taken only after
// the previous one is written back. The result sits in an output register,
// so the next item is taken while a result waits; a stalled receiver holds
// the block in its execute step until the result register drains.
// Reset: the slot memory is not cleared and no clearing pass runs, since data
// read from slots at or above the high mark is never used, and the block is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module versioned_handle_slot_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  vhst_req_if.sink   req_i,
  vhst_rsp_if.source rsp_o
);
  import vhst_pkg::*;

  slot_req_t  slot_req;
  slot_word_t slot_rdata;
  stack_req_t stack_req;
  idx_t       stack_rdata;

  // Controller: sequencing, read-modify-write and result register.
  vhst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .slot_req_o    (slot_req),
    .slot_rdata_i  (slot_rdata),
    .stack_req_o   (stack_req),
    .stack_rdata_i (stack_rdata)
  );

  // Per-slot state storage.
  vhst_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .req_i   (slot_req),
    .rdata_o (slot_rdata)
  );

  // LIFO of freed slot indices.
  vhst_stack_mem u_stack_mem (
    .clk_i   (clk_i),
    .req_i   (stack_req),
    .rdata_o (stack_rdata)
  );

endmodule

>>> tb/versioned_handle_slot_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Versioned handle slot table testbench
// Drives register, free, pending kill, resolve and root operations into the
// slot table and checks every result item against a slot-level model kept
// here. Directed cases come first, then repeated reuse of one slot, root
// counting, a partial fill with scattered frees, and random traffic under
// several idling mixes.
// ----------------------------------------------------------------------------
module versioned_handle_slot_table_test;
  import vhst_pkg::*;

  // Function codes that the block does not implement.
  localparam logic [FUNC_BITS-1:0] FN_UNUSED_LO = 3'd6;
  localparam logic [FUNC_BITS-1:0] FN_UNUSED_HI = 3'd7;

  // Number of slots that the fill test brings into use.
  localparam int FILL_SLOTS = 128;

  // One operation item as it is sent.
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 handle_set;
    idx_t                 index;
    version_t             version;
    object_t              obj;
  } op_t;

  // One result item as it is expected.
  typedef struct packed {
    status_e  status;
    idx_t     index;
    version_t version;
    object_t  obj;
    count_t   live;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vhst_req_if req_if ();
  vhst_rsp_if rsp_if ();

  versioned_handle_slot_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Slot table model state.
  object_t     slot_obj   [SLOTS];
  slot_state_e slot_st    [SLOTS];
  version_t    slot_ver   [SLOTS];
  roots_t      slot_roots [SLOTS];
  idx_t        free_list  [$];
  int          high_mark;
  int          live_slots;

  result_t awaited_results [$];
  result_t last_result;
  result_t head;
  int      fail_count;
  int      send_idle_pct;
  int      stall_pct;

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one operation to the model and returns the result it produces.
  function automatic result_t slot_table_apply(op_t op);
    result_t     r;
    idx_t        i;
    slot_state_e st;
    r.status  = STS_OK;
    r.index   = '0;
    r.version = '0;
    r.obj     = '0;
    case (op.func)
      FN_REGISTER: begin
        if (op.obj == '0) begin
          r.status = STS_NULL;
        end else if (free_list.size() != 0 || high_mark < SLOTS) begin
          if (free_list.size() != 0) begin
            // The most recently freed slot is taken first.
            i = free_list[free_list.size() - 1];
            free_list.delete(free_list.size() - 1);
          end else begin
            i = high_mark[IDX_BITS-1:0];
            high_mark++;
          end
          slot_obj[i]   = op.obj;
          slot_st[i]    = SLOT_LIVE;
          slot_roots[i] = '0;
          live_slots++;
          r.index   = i;
          r.version = slot_ver[i];
        end else begin
          r.status = STS_FULL;
        end
      end
      FN_FREE, FN_PENDING, FN_RESOLVE, FN_ADD_ROOT, FN_REMOVE_ROOT: begin
        i = op.index;
        if (!op.handle_set || op.index >= high_mark || slot_ver[i] != op.version) begin
          r.status = STS_STALE;
        end else begin
          st = slot_st[i];
          if (op.func == FN_FREE) begin
            // Free takes live and pending-kill slots alike.
            if (st != SLOT_FREE) begin
              if (st == SLOT_LIVE) live_slots--;
              slot_obj[i]   = '0;
              slot_st[i]    = SLOT_FREE;
              slot_roots[i] = '0;
              slot_ver[i]   = slot_ver[i] + 1'b1;
              free_list.insert(free_list.size(), i);
            end else begin
              r.status = STS_BAD_STATE;
            end
          end else if (st != SLOT_LIVE) begin
            r.status = STS_BAD_STATE;
          end else begin
            case (op.func)
              FN_PENDING: begin
                slot_st[i]    = SLOT_PENDING;
                slot_roots[i] = '0;
                live_slots--;
              end
              FN_RESOLVE: r.obj = slot_obj[i];
              FN_ADD_ROOT: begin
                if (slot_roots[i] != '1) slot_roots[i] = slot_roots[i] + 1'b1;
              end
              default: begin
                if (slot_roots[i] != '0) slot_roots[i] = slot_roots[i] - 1'b1;
              end
            endcase
          end
        end
      end
      default: r.status = STS_BAD_STATE;
    endcase
    r.live = count_t'(live_slots);
    return r;
  endfunction

  function automatic object_t nonzero_object();
    object_t o;
    do o = $urandom; while (o == '0);
    return o;
  endfunction

  // Sends one item, with random idle cycles first, and records its result.
  task automatic send_op(input logic [FUNC_BITS-1:0] fn, input logic hs, input idx_t idx,
                         input version_t ver, input object_t obj);
    op_t op;
    op.func       = fn;
    op.handle_set = hs;
    op.index      = idx;
    op.version    = ver;
    op.obj        = obj;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= fn;
    req_if.handle_set   <= hs;
    req_if.slot_index   <= idx;
    req_if.slot_version <= ver;
    req_if.object_ref   <= obj;
    do @(posedge clk_i); while (!req_if.ready);
    last_result = slot_table_apply(op);
    awaited_results.insert(awaited_results.size(), last_result);
  endtask

  // Register with random values in the ignored handle fields.
  task automatic send_register(input object_t obj);
    send_op(FN_REGISTER, 1'($urandom), idx_t'($urandom), version_t'($urandom), obj);
  endtask

  // Handle operation on a slot with the slot's current version.
  task automatic send_use(input logic [FUNC_BITS-1:0] fn, input idx_t idx);
    send_op(fn, 1'b1, idx, slot_ver[idx], $urandom);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic test_directed_ops();
    send_op(FN_RESOLVE, 1'b0, '0, '0, '0);
    send_op(FN_REGISTER, 1'b1, '1, '1, '0);
    send_op(FN_REGISTER, 1'b0, '0, '0, '1);
    send_op(FN_REGISTER, 1'b1, '1, '1, 32'h1);
    send_use(FN_RESOLVE, 10'd0);
    send_op(FN_RESOLVE, 1'b0, '0, '0, '0);
    // Index at the high mark and a wrong version are both stale.
    send_op(FN_RESOLVE, 1'b1, 10'd2, '0, '0);
    send_op(FN_RESOLVE, 1'b1, 10'd0, '1, '0);
    send_use(FN_REMOVE_ROOT, 10'd0);
    send_use(FN_ADD_ROOT, 10'd0);
    send_use(FN_REMOVE_ROOT, 10'd0);
    send_use(FN_PENDING, 10'd1);
    send_use(FN_RESOLVE, 10'd1);
    send_use(FN_ADD_ROOT, 10'd1);
    send_use(FN_PENDING, 10'd1);
    send_use(FN_FREE, 10'd1);
    send_use(FN_FREE, 10'd1);
    send_op(FN_FREE, 1'b1, 10'd1, '0, '0);
    send_register(nonzero_object());
    // Freed slots come back in last-in, first-out order.
    send_use(FN_FREE, 10'd0);
    send_use(FN_FREE, 10'd1);
    send_register(nonzero_object());
    send_register(nonzero_object());
    send_op(FN_UNUSED_LO, 1'b1, '0, '0, '1);
    send_op(FN_UNUSED_HI, 1'b1, '1, '1, '1);
  endtask

  // Reuses one slot several times so that its version steps up each time.
  task automatic test_version_bump();
    int k;
    for (k = 0; k < 8; k++) begin
      send_register(nonzero_object());
      send_use(FN_FREE, last_result.index);
    end
  endtask

  // Adds a few roots, removes more than were added, then checks the slot survives.
  task automatic test_root_counting();
    idx_t i;
    int   k;
    send_register(nonzero_object());
    i = last_result.index;
    for (k = 0; k < 4; k++) send_use(FN_ADD_ROOT, i);
    for (k = 0; k < 6; k++) send_use(FN_REMOVE_ROOT, i);
    send_use(FN_ADD_ROOT, i);
    send_use(FN_RESOLVE, i);
    send_use(FN_FREE, i);
  endtask

  // Brings a block of slots into use, then frees most of them in a scattered order.
  task automatic test_fill_and_scatter();
    int k;
    while (free_list.size() != 0 || high_mark < FILL_SLOTS) send_register(nonzero_object());
    send_register('0);
    send_use(FN_RESOLVE, idx_t'(FILL_SLOTS - 1));
    for (k = 0; k < 96; k++) send_use(FN_FREE, idx_t'((k * 37) % FILL_SLOTS));
  endtask

  // Mostly well-formed handles to occupied slots, with stale, empty and wild ones mixed in.
  task automatic test_random_ops(input int count);
    int                   n;
    int                   pick;
    int                   tries;
    logic [FUNC_BITS-1:0] fn;
    logic                 hs;
    idx_t                 i;
    version_t             v;
    object_t              obj;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25)      fn = FN_REGISTER;
      else if (pick < 40) fn = FN_FREE;
      else if (pick < 48) fn = FN_PENDING;
      else if (pick < 66) fn = FN_RESOLVE;
      else if (pick < 80) fn = FN_ADD_ROOT;
      else if (pick < 95) fn = FN_REMOVE_ROOT;
      else if (pick < 97) fn = FN_UNUSED_LO;
      else                fn = FN_UNUSED_HI;
      obj = $urandom;
      if ($urandom_range(29) == 0) obj = '0;
      // Look for an occupied slot below the high mark.
      i = idx_t'($urandom_range(SLOTS - 1));
      if (high_mark > 0) begin
        tries = 0;
        do begin
          i = idx_t'($urandom_range(high_mark - 1));
          tries++;
        end while (slot_st[i] == SLOT_FREE && tries < 12);
      end
      hs = 1'b1;
      v  = slot_ver[i];
      pick = $urandom_range(99);
      if (pick < 8) begin
        v = v - 1'b1;
      end else if (pick < 12) begin
        v = version_t'($urandom);
      end else if (pick < 16) begin
        hs = 1'b0;
      end else if (pick < 22) begin
        i = idx_t'($urandom_range(SLOTS - 1));
        v = slot_ver[i];
      end
      send_op(fn, hs, i, v, obj);
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        head = awaited_results.pop_front();
        if (rsp_if.status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.out_index !== head.index) begin
          $error("out_index: expected %0d, got %0d", head.index, rsp_if.out_index);
          fail_count++;
        end
        if (rsp_if.out_version !== head.version) begin
          $error("out_version: expected %0d, got %0d", head.version, rsp_if.out_version);
          fail_count++;
        end
        if (rsp_if.out_object !== head.obj) begin
          $error("out_object: expected %h, got %h", head.obj, rsp_if.out_object);
          fail_count++;
        end
        if (rsp_if.live_count !== head.live) begin
          $error("live_count: expected %0d, got %0d", head.live, rsp_if.live_count);
          fail_count++;
        end
      end
    end
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int k;
    for (k = 0; k < SLOTS; k++) begin
      slot_st[k]    = SLOT_FREE;
      slot_ver[k]   = '0;
      slot_obj[k]   = '0;
      slot_roots[k] = '0;
    end
    high_mark     = 0;
    live_slots    = 0;
    fail_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FN_REGISTER;
    req_if.handle_set   <= 1'b0;
    req_if.slot_index   <= '0;
    req_if.slot_version <= '0;
    req_if.object_ref   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    wait_for_results();
    test_version_bump();
    test_root_counting();
    wait_for_results();

    send_idle_pct = 24;
    stall_pct     = 24;
    test_fill_and_scatter();
    wait_for_results();

    // Random traffic: no idling, sender idle, receiver stalling, both.
    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_ops(140);
    wait_for_results();
    send_idle_pct = 51;
    test_random_ops(140);
    wait_for_results();
    send_idle_pct = 0;
    stall_pct     = 51;
    test_random_ops(140);
    wait_for_results();
    send_idle_pct = 24;
    stall_pct     = 24;
    test_random_ops(140);
    wait_for_results();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
